@@ sv/atp_pkg.sv @@
// Shared constants for the arrowhead triangle pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package atp_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int SIZE_BITS_DEF  = 16;
endpackage
`default_nettype wire

@@ sv/atp_isqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
// Carries a sideband word alongside; uses atp_pkg defaults.
`timescale 1ns / 1ps
`default_nettype none
module atp_isqrt #(
  parameter int NR  = atp_pkg::COORD_BITS_DEF + 1,
  parameter int SBW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*NR-1:0] in_rad,
  input  wire logic [SBW-1:0]  in_sb,
  output logic                 out_valid,
  output logic [NR-1:0]        out_root,
  output logic [SBW-1:0]       out_sb
);
  import atp_pkg::*;

  localparam int RW = NR + 2;

  logic            v_r    [NR];
  logic [2*NR-1:0] rad_r  [NR];
  logic [RW-1:0]   rem_r  [NR];
  logic [NR-1:0]   root_r [NR];
  logic [SBW-1:0]  sb_r   [NR];

  for (genvar i = 0; i < NR; i++) begin : g_stage
    logic            p_v;
    logic [2*NR-1:0] p_rad;
    logic [RW-1:0]   p_rem;
    logic [NR-1:0]   p_root;
    logic [SBW-1:0]  p_sb;
    logic [RW+1:0]   rsh;
    logic [RW+1:0]   trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_rad  = in_rad;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_sb   = in_sb;
    end else begin : g_next
      assign p_v    = v_r[i-1];
      assign p_rad  = rad_r[i-1];
      assign p_rem  = rem_r[i-1];
      assign p_root = root_r[i-1];
      assign p_sb   = sb_r[i-1];
    end

    // Bring down two radicand bits, try (root << 2) | 1.
    assign rsh   = {p_rem, p_rad[2*NR-1 -: 2]};
    assign trial = (RW+2)'({p_root, 2'b01});
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= p_v;
      end
      if (en) begin
        rad_r[i]  <= p_rad << 2;
        rem_r[i]  <= ge ? RW'(rsh - trial) : RW'(rsh);
        root_r[i] <= {p_root[NR-2:0], ge};
        sb_r[i]   <= p_sb;
      end
    end
  end

  assign out_valid = v_r[NR-1];
  assign out_root  = root_r[NR-1];
  assign out_sb    = sb_r[NR-1];
endmodule
`default_nettype wire

@@ sv/atp_div.sv @@
// Pipelined restoring divider, two dividend lanes sharing one divisor,
// one quotient bit per stage. Uses atp_pkg defaults.
`timescale 1ns / 1ps
`default_nettype none
module atp_div #(
  parameter int NA  = atp_pkg::COORD_BITS_DEF + atp_pkg::SIZE_BITS_DEF,
  parameter int ND  = atp_pkg::COORD_BITS_DEF + 1,
  parameter int SBW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [NA-1:0]  in_a0,
  input  wire logic [NA-1:0]  in_a1,
  input  wire logic [ND-1:0]  in_d,
  input  wire logic [SBW-1:0] in_sb,
  output logic                out_valid,
  output logic [NA-1:0]       out_q0,
  output logic [NA-1:0]       out_q1,
  output logic                out_r0_nz,
  output logic                out_r1_nz,
  output logic [SBW-1:0]      out_sb
);
  import atp_pkg::*;

  logic           v_r  [NA];
  logic [NA-1:0]  a0_r [NA];
  logic [NA-1:0]  a1_r [NA];
  logic [ND-1:0]  r0_r [NA];
  logic [ND-1:0]  r1_r [NA];
  logic [NA-1:0]  q0_r [NA];
  logic [NA-1:0]  q1_r [NA];
  logic [ND-1:0]  d_r  [NA];
  logic [SBW-1:0] sb_r [NA];

  for (genvar i = 0; i < NA; i++) begin : g_stage
    logic           p_v;
    logic [NA-1:0]  p_a0, p_a1, p_q0, p_q1;
    logic [ND-1:0]  p_r0, p_r1, p_d;
    logic [SBW-1:0] p_sb;
    logic [ND:0]    s0, s1, dd;
    logic           ge0, ge1;

    if (i == 0) begin : g_first
      assign p_v  = in_valid;
      assign p_a0 = in_a0;
      assign p_a1 = in_a1;
      assign p_r0 = '0;
      assign p_r1 = '0;
      assign p_q0 = '0;
      assign p_q1 = '0;
      assign p_d  = in_d;
      assign p_sb = in_sb;
    end else begin : g_next
      assign p_v  = v_r[i-1];
      assign p_a0 = a0_r[i-1];
      assign p_a1 = a1_r[i-1];
      assign p_r0 = r0_r[i-1];
      assign p_r1 = r1_r[i-1];
      assign p_q0 = q0_r[i-1];
      assign p_q1 = q1_r[i-1];
      assign p_d  = d_r[i-1];
      assign p_sb = sb_r[i-1];
    end

    assign dd  = {1'b0, p_d};
    assign s0  = {p_r0, p_a0[NA-1]};
    assign s1  = {p_r1, p_a1[NA-1]};
    assign ge0 = (s0 >= dd);
    assign ge1 = (s1 >= dd);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= p_v;
      end
      if (en) begin
        a0_r[i] <= p_a0 << 1;
        a1_r[i] <= p_a1 << 1;
        r0_r[i] <= ge0 ? ND'(s0 - dd) : ND'(s0);
        r1_r[i] <= ge1 ? ND'(s1 - dd) : ND'(s1);
        q0_r[i] <= {p_q0[NA-2:0], ge0};
        q1_r[i] <= {p_q1[NA-2:0], ge1};
        d_r[i]  <= p_d;
        sb_r[i] <= p_sb;
      end
    end
  end

  assign out_valid = v_r[NA-1];
  assign out_q0    = q0_r[NA-1];
  assign out_q1    = q1_r[NA-1];
  assign out_r0_nz = |r0_r[NA-1];
  assign out_r1_nz = |r1_r[NA-1];
  assign out_sb    = sb_r[NA-1];
endmodule
`default_nettype wire

@@ sv/arrowhead_triangle_points.sv @@
// Arrowhead triangle generator: tip, tail and size in, three corners out.
// Pipeline: three front stages, one square-root stage per root bit, the split stage,
// one divider stage per quotient bit, the floor stage and the output register.
// Throughput: one request per cycle unless stalled; set by the fully pipelined
// square root (one root bit a stage) and divider (one quotient bit a stage).
// A stalled output freezes every stage.
// Reset: synchronous active-low rst_n clears every stage valid bit.
// Depends on atp_pkg, atp_isqrt and atp_div.
`timescale 1ns / 1ps
`default_nettype none
module arrowhead_triangle_points #(
  parameter int COORD_BITS = atp_pkg::COORD_BITS_DEF,
  parameter int SIZE_BITS  = atp_pkg::SIZE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // tip_x, tip_y, tail_x, tail_y, arrow_size (low bit up), zero filled
  input  wire logic [((4*COORD_BITS+SIZE_BITS+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // emitted, apex_x, apex_y, barb_a_x, barb_a_y, barb_b_x, barb_b_y (low bit up)
  output logic [((6*COORD_BITS+7+7)/8)*8-1:0] out_tdata
);
  import atp_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int S   = SIZE_BITS;
  localparam int DW  = C + 1;        // coordinate difference
  localparam int PW  = DW + S;       // signed difference times size
  localparam int MW  = C + S;        // magnitude of that product
  localparam int QW  = MW + 2;       // signed floored quotient and sums
  localparam int OW  = C + 1;        // vertex field width
  localparam int OTW = ((6*C+7+7)/8)*8;
  localparam int SB1 = 2*C + 2*PW + 1;
  localparam int SB2 = 2*C + 3;

  // One advance enable for the whole pipe: move whenever the output
  // register is empty or being drained.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Unpack the request.
  logic signed [C-1:0] tip_x, tip_y, tail_x, tail_y;
  logic signed [S-1:0] arrow_size;
  assign tip_x      = in_tdata[C-1:0];
  assign tip_y      = in_tdata[2*C-1:C];
  assign tail_x     = in_tdata[3*C-1:2*C];
  assign tail_y     = in_tdata[4*C-1:3*C];
  assign arrow_size = in_tdata[4*C+S-1:4*C];

  // Stage 1: differences.
  logic                 v1_r;
  logic signed [C-1:0]  tx1_r, ty1_r;
  logic signed [DW-1:0] dx1_r, dy1_r;
  logic signed [S-1:0]  sz1_r;

  // Stage 2: squares and products with the size.
  logic                   v2_r;
  logic signed [C-1:0]    tx2_r, ty2_r;
  logic signed [2*DW-1:0] sqx2_r, sqy2_r;
  logic signed [PW-1:0]   px2_r, py2_r;
  logic                   pos2_r;

  // Stage 3: radicand.
  logic            v3_r;
  logic [2*DW-1:0] rad3_r;
  logic [SB1-1:0]  sb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      tx1_r  <= tip_x;
      ty1_r  <= tip_y;
      dx1_r  <= DW'(tip_x) - DW'(tail_x);
      dy1_r  <= DW'(tip_y) - DW'(tail_y);
      sz1_r  <= arrow_size;
      tx2_r  <= tx1_r;
      ty2_r  <= ty1_r;
      sqx2_r <= dx1_r * dx1_r;
      sqy2_r <= dy1_r * dy1_r;
      px2_r  <= dx1_r * sz1_r;
      py2_r  <= dy1_r * sz1_r;
      pos2_r <= (sz1_r > 0);
      rad3_r <= $unsigned(sqx2_r) + $unsigned(sqy2_r);
      sb3_r  <= {tx2_r, ty2_r, px2_r, py2_r, pos2_r};
    end
  end

  // Length: floored square root.
  logic           v_sq;
  logic [DW-1:0]  len_sq;
  logic [SB1-1:0] sb_sq;

  atp_isqrt #(.NR(DW), .SBW(SB1)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_rad    (rad3_r),
    .in_sb     (sb3_r),
    .out_valid (v_sq),
    .out_root  (len_sq),
    .out_sb    (sb_sq)
  );

  logic signed [C-1:0]  tx_sq, ty_sq;
  logic signed [PW-1:0] px_sq, py_sq;
  logic                 pos_sq;
  assign {tx_sq, ty_sq, px_sq, py_sq, pos_sq} = sb_sq;

  // Stage 4: split products into sign and magnitude for the divider.
  logic           v4_r;
  logic [MW-1:0]  ax4_r, ay4_r;
  logic [DW-1:0]  len4_r;
  logic [SB2-1:0] sb4_r;
  logic [PW-1:0]  npx, npy;
  assign npx = -px_sq;
  assign npy = -py_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v_sq;
    end
    if (en) begin
      ax4_r  <= px_sq[PW-1] ? npx[MW-1:0] : px_sq[MW-1:0];
      ay4_r  <= py_sq[PW-1] ? npy[MW-1:0] : py_sq[MW-1:0];
      len4_r <= len_sq;
      sb4_r  <= {tx_sq, ty_sq, px_sq[PW-1], py_sq[PW-1], pos_sq && (len_sq != '0)};
    end
  end

  // Both back-point quotients in one divider pipe; halves come later.
  logic           v_dv;
  logic [MW-1:0]  qx_dv, qy_dv;
  logic           rx_nz, ry_nz;
  logic [SB2-1:0] sb_dv;

  atp_div #(.NA(MW), .ND(DW), .SBW(SB2)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_a0     (ax4_r),
    .in_a1     (ay4_r),
    .in_d      (len4_r),
    .in_sb     (sb4_r),
    .out_valid (v_dv),
    .out_q0    (qx_dv),
    .out_q1    (qy_dv),
    .out_r0_nz (rx_nz),
    .out_r1_nz (ry_nz),
    .out_sb    (sb_dv)
  );

  logic signed [C-1:0] tx_dv, ty_dv;
  logic                negx_dv, negy_dv, ok_dv;
  assign {tx_dv, ty_dv, negx_dv, negy_dv, ok_dv} = sb_dv;

  // Stage 5: floor toward minus infinity for negative dividends.
  logic                v5_r;
  logic signed [QW-1:0] qx5_r, qy5_r;
  logic signed [C-1:0]  tx5_r, ty5_r;
  logic                 ok5_r;
  logic [QW-1:0]        qx_up, qy_up;
  assign qx_up = QW'(qx_dv) + QW'(rx_nz);
  assign qy_up = QW'(qy_dv) + QW'(ry_nz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v_dv;
    end
    if (en) begin
      qx5_r <= negx_dv ? -qx_up : QW'(qx_dv);
      qy5_r <= negy_dv ? -qy_up : QW'(qy_dv);
      tx5_r <= tx_dv;
      ty5_r <= ty_dv;
      ok5_r <= ok_dv;
    end
  end

  // Output register: corners. floor(p/(2len)) == floor(floor(p/len)/2).
  logic signed [QW-1:0] back_x, back_y, half_x, half_y;
  logic signed [QW-1:0] ax_s, ay_s, bx_s, by_s;
  assign back_x = QW'(tx5_r) - qx5_r;
  assign back_y = QW'(ty5_r) - qy5_r;
  assign half_x = qy5_r >>> 1;
  assign half_y = qx5_r >>> 1;
  assign ax_s   = back_x - half_x;
  assign ay_s   = back_y + half_y;
  assign bx_s   = back_x + half_x;
  assign by_s   = back_y - half_y;

  logic                out_tvalid_r;
  logic                emitted_r;
  logic [OW-1:0]       apex_x_r, apex_y_r;
  logic [OW-1:0]       barb_a_x_r, barb_a_y_r, barb_b_x_r, barb_b_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= v5_r;
    end
    if (en) begin
      emitted_r  <= ok5_r;
      // Drop every coordinate to zero when no triangle is produced.
      apex_x_r   <= ok5_r ? OW'(tx5_r) : '0;
      apex_y_r   <= ok5_r ? OW'(ty5_r) : '0;
      barb_a_x_r <= ok5_r ? ax_s[OW-1:0] : '0;
      barb_a_y_r <= ok5_r ? ay_s[OW-1:0] : '0;
      barb_b_x_r <= ok5_r ? bx_s[OW-1:0] : '0;
      barb_b_y_r <= ok5_r ? by_s[OW-1:0] : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OTW'({barb_b_y_r, barb_b_x_r, barb_a_y_r, barb_a_x_r,
                            apex_y_r, apex_x_r, emitted_r});

  // A request without a triangle carries zero apex_x, barb_a_x and barb_b_y.
  a_zero_when_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !emitted_r |-> apex_x_r == '0 && barb_a_x_r == '0 && barb_b_y_r == '0)
    else $error("coordinates not cleared for dropped triangle");

  // The apex of an emitted triangle is the tip that stage 5 held in the cycle before.
  a_apex_tip: assert property (@(posedge clk) disable iff (!rst_n)
    en && v5_r && ok5_r |=> apex_x_r == OW'($past(tx5_r)))
    else $error("apex does not follow tip");

  // A stalled output must keep the whole pipe frozen.
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(v5_r))
    else $error("pipe advanced during stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !v5_r && !v1_r)
    else $error("valid bits survive reset");
endmodule
`default_nettype wire

@@ dv/atp_checker.sv @@
// Checker for the arrowhead triangle block: watches both stream channels,
// predicts each triangle and compares it field by field. Depends on atp_pkg.
`timescale 1ns / 1ps
module atp_checker #(
  parameter int COORD_BITS = atp_pkg::COORD_BITS_DEF,
  parameter int SIZE_BITS  = atp_pkg::SIZE_BITS_DEF,
  parameter int IN_W       = ((4*COORD_BITS+SIZE_BITS+7)/8)*8,
  parameter int OUT_W      = ((6*COORD_BITS+7+7)/8)*8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  output int              fail_count,
  output int              pending,
  output int              triangles_seen,
  output int              empties_seen
);
  localparam int OB = COORD_BITS + 1;

  logic [6*OB:0] triangle_q[$];

  assign pending = triangle_q.size();

  function automatic longint sext(logic [63:0] v, int bits);
    longint r;
    r = v & ((64'd1 << bits) - 1);
    if (v[bits-1]) r = r - (longint'(1) << bits);
    return r;
  endfunction

  function automatic longint div_down(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && (a < 0)) q = q - 1;
    return q;
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
        r = r + (longint'(1) << b);
    return r;
  endfunction

  // pack: emitted, then six coordinates, low bit up
  function automatic logic [6*OB:0] predict_triangle(logic [IN_W-1:0] d);
    longint tx, ty, fx, fy, sz, dx, dy, len, bx, by, hx, hy;
    logic [6*OB:0] r;
    tx = sext(d[0 +: COORD_BITS], COORD_BITS);
    ty = sext(d[COORD_BITS +: COORD_BITS], COORD_BITS);
    fx = sext(d[2*COORD_BITS +: COORD_BITS], COORD_BITS);
    fy = sext(d[3*COORD_BITS +: COORD_BITS], COORD_BITS);
    sz = sext(d[4*COORD_BITS +: SIZE_BITS], SIZE_BITS);
    dx = tx - fx;
    dy = ty - fy;
    r = '0;
    if (sz <= 0) return r;
    len = floor_sqrt(dx*dx + dy*dy);
    if (len == 0) return r;
    bx = tx - div_down(dx*sz, len);
    by = ty - div_down(dy*sz, len);
    hx = div_down(dy*sz, 2*len);
    hy = div_down(dx*sz, 2*len);
    r[0] = 1'b1;
    r[1 + 0*OB +: OB] = tx[OB-1:0];
    r[1 + 1*OB +: OB] = ty[OB-1:0];
    r[1 + 2*OB +: OB] = OB'(bx - hx);
    r[1 + 3*OB +: OB] = OB'(by + hy);
    r[1 + 4*OB +: OB] = OB'(bx + hx);
    r[1 + 5*OB +: OB] = OB'(by - hy);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    triangles_seen = 0;
    empties_seen = 0;
  end

  always @(posedge clk) begin
    logic [6*OB:0] want;
    string names[7];
    names = '{"emitted", "apex_x", "apex_y", "barb_a_x", "barb_a_y", "barb_b_x", "barb_b_y"};
    if (rst_n) begin
      if (in_tvalid && in_tready)
        triangle_q.insert(triangle_q.size(), predict_triangle(in_tdata));
      if (out_tvalid && out_tready) begin
        if (triangle_q.size() == 0) begin
          report_mismatch("result with nothing pending", 0, 0);
        end else begin
          want = triangle_q.pop_front();
          if (want[0]) triangles_seen++; else empties_seen++;
          if (out_tdata[0] !== want[0]) report_mismatch(names[0], out_tdata[0], want[0]);
          for (int f = 0; f < 6; f++)
            if (out_tdata[1 + f*OB +: OB] !== want[1 + f*OB +: OB])
              report_mismatch(names[f+1], sext(out_tdata[1 + f*OB +: OB], OB),
                              sext(want[1 + f*OB +: OB], OB));
        end
      end
    end
  end
endmodule

@@ dv/tb.sv @@
// Top of the arrowhead triangle testbench: clock, reset, stimulus and verdict.
// Depends on atp_pkg, arrowhead_triangle_points and atp_checker.
`timescale 1ns / 1ps
module tb;
  localparam int CB    = atp_pkg::COORD_BITS_DEF;
  localparam int SB    = atp_pkg::SIZE_BITS_DEF;
  localparam int IN_W  = ((4*CB+SB+7)/8)*8;
  localparam int OUT_W = ((6*CB+7+7)/8)*8;
  localparam int LATENCY = 2*CB + SB + 7;
  localparam int RANDOM_REQS = 1430;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  int fail_count, pending, triangles_seen, empties_seen;
  longint cycles = 0;
  int n_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  arrowhead_triangle_points u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  atp_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending),
    .triangles_seen(triangles_seen), .empties_seen(empties_seen)
  );

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side: draw a wait per accepted result, with quiet stretches.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (($urandom_range(0, 7) == 0)) stall = 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
    end
  end

  // Hold one request until accepted, after a random gap if gaps is set.
  task automatic send_request(logic [CB-1:0] tx, logic [CB-1:0] ty, logic [CB-1:0] fx,
                              logic [CB-1:0] fy, logic [SB-1:0] sz, bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({sz, fy, fx, ty, tx});
    @(posedge clk iff in_tready);
    n_sent++;
  endtask

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CB'($urandom);
      1: return CB'($urandom_range(0, 200)) - CB'(100);
      2: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      default: return CB'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [CB-1:0] tx, ty;
    int drain;
    localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero/negative size, zero length, axis and diagonal arrows.
    send_request(0, 0, 0, 0, 10, 0);
    send_request(5, 5, 5, 5, SMAX, 0);
    send_request(10, 0, 0, 0, 0, 0);
    send_request(10, 0, 0, 0, -1, 0);
    send_request(10, 0, 0, 0, SMIN, 0);
    send_request(10, 0, 0, 0, 3, 0);
    send_request(0, 10, 0, 0, 3, 0);
    send_request(-10, 0, 0, 0, 3, 0);
    send_request(0, -10, 0, 0, 7, 0);
    send_request(3, 4, 0, 0, 5, 0);
    send_request(-3, -4, 0, 0, 1, 0);
    send_request(CMAX, CMAX, CMIN, CMIN, SMAX, 0);
    send_request(CMIN, CMIN, CMAX, CMAX, SMAX, 0);
    send_request(CMAX, CMIN, CMIN, CMAX, 1, 0);
    send_request(CMIN, CMAX, CMAX, CMIN, 2, 0);
    send_request(CMAX, 0, CMAX - 1, 0, SMAX, 0);
    send_request(CMIN, CMIN, CMIN, CMIN + 1, SMAX, 0);
    send_request(1, 1, 0, 0, SMAX, 0);
    send_request(-1, 1, 0, 0, 100, 0);
    send_request(CMAX, CMAX, 0, 0, 1, 0);
    send_request(0, 0, CMIN, CMAX, 12345, 0);

    // Random: mostly valid arrows, with some empty cases mixed in.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      tx = rand_coord();
      ty = rand_coord();
      case ($urandom_range(0, 9))
        0: send_request(tx, ty, tx, ty, SB'($urandom), 1);
        1: send_request(tx, ty, rand_coord(), rand_coord(), SMIN | SB'($urandom), 1);
        2: send_request(tx, ty, tx + CB'($urandom_range(0, 6)) - CB'(3),
                        ty + CB'($urandom_range(0, 6)) - CB'(3), SB'($urandom_range(0, 32767)), 1);
        default: send_request(tx, ty, rand_coord(), rand_coord(),
                              $urandom_range(0, 1) ? SB'($urandom_range(1, 32767))
                                                   : SB'($urandom_range(1, 64)), 1);
      endcase
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (pending != 0) $display("%0d results never arrived", pending);
    $display("Sent %0d arrow requests: %0d triangles and %0d empty results checked",
             n_sent, triangles_seen, empties_seen);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
